[hdl/bpf_pkg.sv]
// Shared types and constants for the path flattener.
package bpf_pkg;

  localparam int COORD_W  = 16;
  localparam int FLAT_W   = 16;
  localparam int DIFF_W   = 37;
  localparam int LHS_W    = 20;
  localparam int LHS_SAT  = 1 << 19;
  localparam int DIV_BITS = 17;
  localparam int FLAT_RST = 4;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic                       lead;
    logic signed [COORD_W-1:0]  p0x;
    logic signed [COORD_W-1:0]  p0y;
    logic signed [COORD_W-1:0]  c1x;
    logic signed [COORD_W-1:0]  c1y;
    logic signed [COORD_W-1:0]  c2x;
    logic signed [COORD_W-1:0]  c2y;
    logic signed [COORD_W-1:0]  ex;
    logic signed [COORD_W-1:0]  ey;
  } entry_t;

endpackage

[hdl/bezier_path_flattener.sv]
// Top level of the Bezier path flattener.
// The flattener takes path commands one word at a time and returns polyline
// vertices in Q12.4. A move gives one vertex, a line one vertex, and a curve
// n vertices at t = i/n, where n is the smallest count up to MAX_SEGMENTS
// whose flatness bound covers the curve's largest second difference; a line
// or curve with no subpath open first repeats the pen as a subpath start.
// The front end accepts a command, works out the second differences and then
// tries candidate segment counts in turn; a two-word queue lets it take the
// next command while vertices still flow. For each curve vertex the back end
// spends most of its time in the 17-step bit-serial divider that rounds each
// point; a leading subpath start is emitted first. Flatness is written
// through cfg_wr_en; the user must do so only while idle, which the block
// itself never enforces.
module bezier_path_flattener #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // flatness, unsigned Q12.4
  input  logic        in_tvalid,
  output logic        in_tready,
  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,      // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // vert_x, vert_y
  output logic        out_tlast,     // last
  output logic        out_tuser      // starts_subpath
);

  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int QW = $bits(bpf_pkg::entry_t) + NW;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  bpf_pkg::entry_t  push_entry, pop_entry;
  logic [NW-1:0]    push_n, pop_n;
  logic [QW-1:0]    q_rd;

  bpf_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .NW(NW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry),
    .push_n      (push_n)
  );

  bpf_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_n, push_entry}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (q_rd)
  );

  assign pop_entry = bpf_pkg::entry_t'(q_rd[QW-NW-1:0]);
  assign pop_n     = q_rd[QW-1:QW-NW];

  bpf_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .NW(NW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .pop_n      (pop_n),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[hdl/bpf_front.sv]
// Front end: takes commands, tracks the pen and picks the segment count.
module bpf_front #(
  parameter int MAX_SEGMENTS = 32,
  parameter int NW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bpf_pkg::FLAT_W-1:0]     cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output bpf_pkg::entry_t                push_entry,
  output logic [NW-1:0]                  push_n
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_DA   = 6'b000010,
    F_DB   = 6'b000100,
    F_SA   = 6'b001000,
    F_SB   = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t                          state_r, state_nxt;
  logic [bpf_pkg::FLAT_W-1:0]       flat_r;
  logic signed [15:0]               pen_x_r, pen_y_r;
  logic                             open_r;
  bpf_pkg::entry_t                  ent_r;
  logic [bpf_pkg::DIFF_W-1:0]       d2_r;
  logic [bpf_pkg::LHS_W-1:0]        lhs_r;
  logic [NW-1:0]                    n_r;
  logic [2*NW-1:0]                  nsq_r;

  logic signed [15:0]               ax, bx, cx, ay, by, cy;
  logic signed [17:0]               dx, dy;
  logic [bpf_pkg::DIFF_W-1:0]       dsq;
  logic [bpf_pkg::FLAT_W-1:0]       fl;
  logic [bpf_pkg::FLAT_W+2*NW+2:0]  lhs_raw;
  logic [2*bpf_pkg::LHS_W-1:0]      lhs_sq;
  logic                             accept;
  bpf_pkg::cmd_t                    in_cmd;

  assign in_tready  = (state_r == F_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_cmd     = bpf_pkg::cmd_t'(in_tuser);
  assign push_valid = (state_r == F_PUSH);
  assign push_entry = ent_r;
  assign push_n     = n_r;

  // One second difference per cycle; the cubic takes its two in turn.
  always_comb begin
    if (state_r == F_DB) begin
      ax = ent_r.c1x; bx = ent_r.c2x; cx = ent_r.ex;
      ay = ent_r.c1y; by = ent_r.c2y; cy = ent_r.ey;
    end else begin
      ax = ent_r.p0x; bx = ent_r.c1x;
      ay = ent_r.p0y; by = ent_r.c1y;
      cx = (ent_r.cmd == bpf_pkg::CMD_CUBIC) ? ent_r.c2x : ent_r.ex;
      cy = (ent_r.cmd == bpf_pkg::CMD_CUBIC) ? ent_r.c2y : ent_r.ey;
    end
    dx  = 18'(ax) - (18'(bx) <<< 1) + 18'(cx);
    dy  = 18'(ay) - (18'(by) <<< 1) + 18'(cy);
    dsq = bpf_pkg::DIFF_W'(unsigned'(36'(dx) * 36'(dx))) +
          bpf_pkg::DIFF_W'(unsigned'(36'(dy) * 36'(dy)));
  end

  always_comb begin
    fl      = (flat_r == '0) ? bpf_pkg::FLAT_W'(1) : flat_r;
    lhs_raw = (($bits(lhs_raw))'(fl) * ($bits(lhs_raw))'(nsq_r)) << 3;
    lhs_sq  = lhs_r * lhs_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_cmd == bpf_pkg::CMD_MOVE || in_cmd == bpf_pkg::CMD_LINE) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_DA;
          end
        end
      end
      F_DA:   state_nxt = (ent_r.cmd == bpf_pkg::CMD_CUBIC) ? F_DB : F_SA;
      F_DB:   state_nxt = F_SA;
      F_SA:   state_nxt = F_SB;
      F_SB: begin
        if ((lhs_sq >= (2*bpf_pkg::LHS_W)'(d2_r)) || (n_r == NW'(MAX_SEGMENTS))) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_SA;
        end
      end
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      flat_r  <= bpf_pkg::FLAT_W'(bpf_pkg::FLAT_RST);
      pen_x_r <= '0;
      pen_y_r <= '0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) flat_r <= cfg_wr_data;
      if (accept) begin
        pen_x_r <= in_tdata[79:64];
        pen_y_r <= in_tdata[95:80];
        open_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          ent_r.cmd  <= in_cmd;
          ent_r.lead <= !open_r && (in_cmd != bpf_pkg::CMD_MOVE);
          ent_r.p0x  <= pen_x_r;
          ent_r.p0y  <= pen_y_r;
          ent_r.c1x  <= in_tdata[15:0];
          ent_r.c1y  <= in_tdata[31:16];
          ent_r.c2x  <= in_tdata[47:32];
          ent_r.c2y  <= in_tdata[63:48];
          ent_r.ex   <= in_tdata[79:64];
          ent_r.ey   <= in_tdata[95:80];
          n_r        <= NW'(1);
          nsq_r      <= (2*NW)'(1);
        end
      end
      F_DA: d2_r <= dsq;
      F_DB: if (dsq > d2_r) d2_r <= dsq;
      F_SA: begin
        if (lhs_raw > ($bits(lhs_raw))'(bpf_pkg::LHS_SAT)) begin
          lhs_r <= bpf_pkg::LHS_W'(bpf_pkg::LHS_SAT);
        end else begin
          lhs_r <= lhs_raw[bpf_pkg::LHS_W-1:0];
        end
      end
      F_SB: begin
        if (state_nxt == F_SA) begin
          n_r   <= n_r + NW'(1);
          nsq_r <= nsq_r + ((2*NW)'(n_r) << 1) + (2*NW)'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/bpf_queue.sv]
// Two-entry queue between the front end and the vertex generator.
module bpf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[hdl/bpf_back.sv]
// Back end: generates the vertices of each queued command.
module bpf_back #(
  parameter int MAX_SEGMENTS = 32,
  parameter int NW = $clog2(MAX_SEGMENTS + 1),
  parameter int WW = 3 * NW,
  parameter int PW = WW + 17,
  parameter int SW = WW + 18,
  parameter int AW = WW + 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  bpf_pkg::entry_t  pop_entry,
  input  logic [NW-1:0]    pop_n,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  typedef enum logic [8:0] {
    B_IDLE   = 9'b000000001,
    B_LEAD   = 9'b000000010,
    B_SINGLE = 9'b000000100,
    B_W1     = 9'b000001000,
    B_W2     = 9'b000010000,
    B_ACC    = 9'b000100000,
    B_PREP   = 9'b001000000,
    B_DIV    = 9'b010000000,
    B_EMIT   = 9'b100000000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  bpf_pkg::entry_t     e_r;
  logic [NW-1:0]       n_r, i_r;
  logic [2*NW-1:0]     uu_r, ii_r, ui_r, nn_r;
  logic [WW-1:0]       w_r [4];
  logic [WW-1:0]       den_r;
  logic [1:0]          k_r;
  logic signed [SW-1:0] accx_r, accy_r;
  logic [AW-1:0]       remx_r, remy_r, dsh_r;
  logic [bpf_pkg::DIV_BITS-1:0] qx_r, qy_r;
  logic [4:0]          bit_r;
  logic                ovld_r, olast_r, ostart_r;
  logic [15:0]         ox_r, oy_r;

  logic                can_load, is_curve, is_cubic;
  logic [NW-1:0]       u;
  logic signed [15:0]  cx, cy;
  logic signed [PW-1:0] px, py;
  logic [3*NW-1:0]     t_uui, t_iiu;
  logic [WW:0]         dvs;
  logic [AW-1:0]       ax, ay;

  assign can_load   = !ovld_r || out_tready;
  assign pop_ready  = (state_r == B_IDLE);
  assign is_curve   = (e_r.cmd == bpf_pkg::CMD_QUAD) || (e_r.cmd == bpf_pkg::CMD_CUBIC);
  assign is_cubic   = (e_r.cmd == bpf_pkg::CMD_CUBIC);
  assign out_tvalid = ovld_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = ostart_r;

  always_comb begin
    u     = n_r - i_r;
    t_uui = uu_r * i_r;
    t_iiu = ii_r * u;
    dvs   = {den_r, 1'b0};
    case (k_r)
      2'd0:    begin cx = e_r.p0x; cy = e_r.p0y; end
      2'd1:    begin cx = e_r.c1x; cy = e_r.c1y; end
      2'd2:    begin cx = e_r.c2x; cy = e_r.c2y; end
      default: begin cx = e_r.ex;  cy = e_r.ey;  end
    endcase
    px = $signed({1'b0, w_r[k_r]}) * cx;
    py = $signed({1'b0, w_r[k_r]}) * cy;
    // Rounded floor division is biased so that the dividend is never negative.
    ax = ({{(AW-SW){accx_r[SW-1]}}, accx_r} << 1) + AW'(den_r) + (AW'(dvs) << 16);
    ay = ({{(AW-SW){accy_r[SW-1]}}, accy_r} << 1) + AW'(den_r) + (AW'(dvs) << 16);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_entry.lead) begin
            state_nxt = B_LEAD;
          end else if (pop_entry.cmd == bpf_pkg::CMD_QUAD ||
                       pop_entry.cmd == bpf_pkg::CMD_CUBIC) begin
            state_nxt = B_W1;
          end else begin
            state_nxt = B_SINGLE;
          end
        end
      end
      B_LEAD:   if (can_load) state_nxt = is_curve ? B_W1 : B_SINGLE;
      B_SINGLE: if (can_load) state_nxt = B_IDLE;
      B_W1:     state_nxt = B_W2;
      B_W2:     state_nxt = B_ACC;
      B_ACC:    if (k_r == 2'd3) state_nxt = B_PREP;
      B_PREP:   state_nxt = B_DIV;
      B_DIV:    if (bit_r == 5'd0) state_nxt = B_EMIT;
      B_EMIT:   if (can_load) state_nxt = (i_r == n_r) ? B_IDLE : B_W1;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_LEAD || state_r == B_SINGLE || state_r == B_EMIT) && can_load) begin
        ovld_r <= 1'b1;
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          e_r <= pop_entry;
          n_r <= pop_n;
          i_r <= NW'(1);
        end
      end
      B_LEAD: begin
        if (can_load) begin
          ox_r <= e_r.p0x; oy_r <= e_r.p0y; ostart_r <= 1'b1; olast_r <= 1'b0;
        end
      end
      B_SINGLE: begin
        if (can_load) begin
          ox_r     <= e_r.ex;
          oy_r     <= e_r.ey;
          ostart_r <= (e_r.cmd == bpf_pkg::CMD_MOVE);
          olast_r  <= 1'b1;
        end
      end
      B_W1: begin
        uu_r <= u * u;
        ii_r <= i_r * i_r;
        ui_r <= u * i_r;
        nn_r <= n_r * n_r;
      end
      B_W2: begin
        if (is_cubic) begin
          w_r[0] <= WW'(uu_r) * WW'(u);
          w_r[1] <= WW'((t_uui << 1) + t_uui);
          w_r[2] <= WW'((t_iiu << 1) + t_iiu);
          w_r[3] <= WW'(ii_r) * WW'(i_r);
          den_r  <= WW'(nn_r) * WW'(n_r);
        end else begin
          w_r[0] <= WW'(uu_r);
          w_r[1] <= WW'(ui_r) << 1;
          w_r[2] <= '0;
          w_r[3] <= WW'(ii_r);
          den_r  <= WW'(nn_r);
        end
        accx_r <= '0;
        accy_r <= '0;
        k_r    <= 2'd0;
      end
      B_ACC: begin
        accx_r <= accx_r + {px[PW-1], px};
        accy_r <= accy_r + {py[PW-1], py};
        k_r    <= k_r + 2'd1;
      end
      B_PREP: begin
        remx_r <= ax;
        remy_r <= ay;
        dsh_r  <= AW'(dvs) << (bpf_pkg::DIV_BITS - 1);
        qx_r   <= '0;
        qy_r   <= '0;
        bit_r  <= 5'(bpf_pkg::DIV_BITS - 1);
      end
      B_DIV: begin
        if (remx_r >= dsh_r) begin
          remx_r <= remx_r - dsh_r;
          qx_r   <= {qx_r[bpf_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          qx_r   <= {qx_r[bpf_pkg::DIV_BITS-2:0], 1'b0};
        end
        if (remy_r >= dsh_r) begin
          remy_r <= remy_r - dsh_r;
          qy_r   <= {qy_r[bpf_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          qy_r   <= {qy_r[bpf_pkg::DIV_BITS-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        bit_r <= bit_r - 5'd1;
      end
      B_EMIT: begin
        if (can_load) begin
          ox_r     <= qx_r[15:0];
          oy_r     <= qy_r[15:0];
          ostart_r <= 1'b0;
          olast_r  <= (i_r == n_r);
          i_r      <= i_r + NW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/bpf_checker.sv]
// Port-level checks for the path flattener, bound to the top level.
module bpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // Nothing is presented in the cycle after a reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid straight after reset");

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

  // The front end is busy in the cycle after taking a word.
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind bezier_path_flattener bpf_checker u_bpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[tb/sv/bpf_checker.sv]
`timescale 1ns / 100ps
// Checker for the path flattener: predicts vertices from accepted commands and compares them.
module bpf_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          vert_count
);

  localparam int SEG_LIMIT = 32;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        starts;
    logic        fin;
  } vertex_t;

  vertex_t     vert_q[$];
  logic [15:0] flat_reg;
  longint      pen_px, pen_py;
  bit          open_path;

  function automatic longint div_nearest(longint num, longint den);
    longint n2, d2, q;
    n2 = 2 * num + den;
    d2 = 2 * den;
    q  = n2 / d2;
    if ((n2 % d2) != 0 && n2 < 0) q -= 1;
    return q;
  endfunction

  function automatic longint bend_sq(longint a, longint b, longint c,
                                     longint p, longint q, longint r);
    longint dx, dy;
    dx = a - 2 * b + c;
    dy = p - 2 * q + r;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint seg_count(longint d2);
    longint f, lhs;
    f = (flat_reg == 0) ? 1 : flat_reg;
    for (int n = 1; n < SEG_LIMIT; n++) begin
      lhs = 8 * f * n * n;
      if (lhs > (1 << 19)) lhs = 1 << 19;
      if (lhs * lhs >= d2) return n;
    end
    return SEG_LIMIT;
  endfunction

  task automatic push_vert(longint x, longint y, bit s, bit l);
    vertex_t v;
    v.x = x[15:0];
    v.y = y[15:0];
    v.starts = s;
    v.fin = l;
    vert_q.push_back(v);
  endtask

  task automatic predict_cmd(bpf_pkg::cmd_t cmd, logic [95:0] d);
    longint c1x, c1y, c2x, c2y, ex, ey, n, u, w0, w1, w2, w3, da, db;
    c1x = longint'($signed(d[15:0]));
    c1y = longint'($signed(d[31:16]));
    c2x = longint'($signed(d[47:32]));
    c2y = longint'($signed(d[63:48]));
    ex  = longint'($signed(d[79:64]));
    ey  = longint'($signed(d[95:80]));
    if (cmd != bpf_pkg::CMD_MOVE && !open_path) push_vert(pen_px, pen_py, 1, 0);
    open_path = 1;
    case (cmd)
      bpf_pkg::CMD_MOVE: push_vert(ex, ey, 1, 1);
      bpf_pkg::CMD_LINE: push_vert(ex, ey, 0, 1);
      bpf_pkg::CMD_QUAD: begin
        n = seg_count(bend_sq(pen_px, c1x, ex, pen_py, c1y, ey));
        for (longint i = 1; i <= n; i++) begin
          u = n - i;
          w0 = u * u; w1 = 2 * i * u; w2 = i * i;
          push_vert(div_nearest(w0 * pen_px + w1 * c1x + w2 * ex, n * n),
                    div_nearest(w0 * pen_py + w1 * c1y + w2 * ey, n * n), 0, i == n);
        end
      end
      default: begin
        da = bend_sq(pen_px, c1x, c2x, pen_py, c1y, c2y);
        db = bend_sq(c1x, c2x, ex, c1y, c2y, ey);
        n = seg_count(da > db ? da : db);
        for (longint i = 1; i <= n; i++) begin
          u = n - i;
          w0 = u * u * u; w1 = 3 * u * u * i; w2 = 3 * u * i * i; w3 = i * i * i;
          push_vert(div_nearest(w0 * pen_px + w1 * c1x + w2 * c2x + w3 * ex, n * n * n),
                    div_nearest(w0 * pen_py + w1 * c1y + w2 * c2y + w3 * ey, n * n * n),
                    0, i == n);
        end
      end
    endcase
    pen_px = ex;
    pen_py = ey;
  endtask

  assign pending = vert_q.size();

  always @(posedge clk) begin
    vertex_t want, got;
    if (!rst_n) begin
      flat_reg   <= 16'(bpf_pkg::FLAT_RST);
      pen_px     = 0;
      pen_py     = 0;
      open_path  = 0;
      fail_count <= 0;
      vert_count <= 0;
      vert_q.delete();
    end else begin
      if (cfg_wr_en) flat_reg <= cfg_wr_data;
      // Outputs are compared before the new command is predicted, so a
      // same-cycle input cannot disturb the queue order.
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tuser, out_tlast};
        vert_count <= vert_count + 1;
        if (vert_q.size() == 0) begin
          $display("%0t: unexpected vertex x=%0d y=%0d", $time,
                   $signed(got.x), $signed(got.y));
          fail_count <= fail_count + 1;
        end else begin
          want = vert_q.pop_front();
          if (want !== got) begin
            $display("%0t: vertex expected x=%0d y=%0d s=%0b l=%0b, got x=%0d y=%0d s=%0b l=%0b",
                     $time, $signed(want.x), $signed(want.y), want.starts, want.fin,
                     $signed(got.x), $signed(got.y), got.starts, got.fin);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_cmd(bpf_pkg::cmd_t'(in_tuser), in_tdata);
    end
  end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the path flattener: stimulus, stalls and verdict.
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int fail_count, pending, vert_count;
  int cmd_count = 0;
  // Idling is switched off during one stretch so the block runs flat out.
  bit calm = 1'b0;
  // While set, the receiver refuses every word so the input queue fills.
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  bezier_path_flattener #(.MAX_SEGMENTS(32)) u_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_tvalid, .in_tready,
    .in_tdata, .in_tuser, .out_tvalid, .out_tready, .out_tdata,
    .out_tlast, .out_tuser
  );

  bpf_tb_checker u_chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_tvalid, .in_tready,
    .in_tdata, .in_tuser, .out_tvalid, .out_tready, .out_tdata,
    .out_tlast, .out_tuser, .fail_count, .pending, .vert_count
  );

  // Receiver: ready is dropped at random about one time in ten, except in the calm
  // stretch, and stays low throughout a hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && (calm || $urandom_range(99) >= 10);
  end

  // Sends one command, with an occasional idle gap before it.
  task automatic send_cmd(bpf_pkg::cmd_t cmd, logic [15:0] c1x, logic [15:0] c1y,
                          logic [15:0] c2x, logic [15:0] c2y,
                          logic [15:0] ex, logic [15:0] ey);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ey, ex, c2y, c2x, c1y, c1x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cmd_count++;
  endtask

  // Coordinates mostly near the origin so curves take moderate counts,
  // sometimes anywhere in the full signed range.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(99) < 20) return 16'($urandom);
    return 16'($signed($urandom_range(1200)) - 600);
  endfunction

  task automatic send_random();
    int r;
    bpf_pkg::cmd_t cmd;
    r = $urandom_range(99);
    cmd = r < 10 ? bpf_pkg::CMD_MOVE : r < 25 ? bpf_pkg::CMD_LINE :
          r < 60 ? bpf_pkg::CMD_QUAD : bpf_pkg::CMD_CUBIC;
    send_cmd(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord());
  endtask

  // Lets every expected vertex drain, then waits out any back-end tail so
  // the flatness register is only written while the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_flatness(logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] flat_set[5];
    flat_set = '{16'd0, 16'd1, 16'd65535, 16'd37, 16'd4};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset flatness: a line with no subpath open
    // repeats the pen first, then extreme coordinates and every command.
    send_cmd(bpf_pkg::CMD_LINE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000);
    send_cmd(bpf_pkg::CMD_QUAD, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000);
    send_cmd(bpf_pkg::CMD_CUBIC, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    send_cmd(bpf_pkg::CMD_CUBIC, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_cmd(bpf_pkg::CMD_MOVE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
    send_cmd(bpf_pkg::CMD_QUAD, 16'd0, 16'd0, 16'h5555, 16'haaaa, 16'd0, 16'd0);
    send_cmd(bpf_pkg::CMD_QUAD, 16'd3, 16'hfffd, 16'd0, 16'd0, 16'd1, 16'hffff);
    send_cmd(bpf_pkg::CMD_CUBIC, 16'd1, 16'd2, 16'hfffe, 16'hffff, 16'd5, 16'hfffb);
    send_cmd(bpf_pkg::CMD_LINE, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'h8000, 16'h8000);
    send_cmd(bpf_pkg::CMD_MOVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff);
    send_cmd(bpf_pkg::CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7fff);
    drain();

    // Random part over several flatness settings, zero and the extremes
    // included; one phase runs with no idling at all.
    foreach (flat_set[k]) begin
      write_flatness(flat_set[k]);
      calm = (k == 3);
      for (int i = 0; i < 70; i++) send_random();
      drain();
    end
    calm = 1'b0;

    // Long receiver hold-off while commands keep coming, so the queue fills
    // and in_tready must fall.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_random();
    join
    drain();

    $display("Covered %0d commands and %0d vertices over five flatness settings,",
             cmd_count, vert_count);
    $display("including zero and full-scale flatness and a long output stall.");
    if (fail_count == 0) $display("bezier_path_flattener: match");
    else $display("bezier_path_flattener: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("bezier_path_flattener: mismatch");
    $finish;
  end
endmodule
